>>> sv/dpr_pkg.sv
// ----------------------------------------------------------------------------
// Digipeater path rewrite package
// Shared types, codes and sizes for the path rewrite block, its address
// match unit, its RAMs and its checker.
// ----------------------------------------------------------------------------
package dpr_pkg;

  localparam int ADDR_W      = 56;
  localparam int TAB_W       = 59;
  localparam int TABLE_DEPTH = 16;
  localparam int TIDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int TIDX_N      = 1 << TIDX_W;
  localparam int TAB_DEPTH   = 3 * TIDX_N;
  localparam int TAB_AW      = TIDX_W + 2;
  localparam int MAX_PATH    = 8;
  localparam int SLOT_W      = 3;
  localparam int COUNT_W     = 4;
  localparam int REG_IDX_W   = 2;

  localparam logic [TIDX_W-1:0] IDX_LAST = TIDX_W'(TABLE_DEPTH - 1);

  // AX.25 SSID byte fields
  localparam logic [7:0] SSID_HOPS  = 8'h1e;
  localparam logic [7:0] USED_BIT   = 8'h80;
  localparam logic [7:0] SSID_DONE  = 8'he0;
  localparam logic [7:0] SSID_FIXED = 8'h60;

  // Command codes
  localparam logic [1:0] FUNC_LOAD_TABLE = 2'd0;
  localparam logic [1:0] FUNC_LOAD_PATH  = 2'd1;
  localparam logic [1:0] FUNC_PROCESS    = 2'd2;

  // Table selects
  localparam logic [1:0] LIST_PLAIN  = 2'd0;
  localparam logic [1:0] LIST_TRACE  = 2'd1;
  localparam logic [1:0] LIST_FLOOD  = 2'd2;
  localparam logic [1:0] LIST_UNUSED = 2'd3;

  // Result actions
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_PLAIN = 2'd1;
  localparam logic [1:0] ACT_TRACE = 2'd2;
  localparam logic [1:0] ACT_FLOOD = 2'd3;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_OWN_CALL  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_TRACE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_FLOOD = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [1:0]         list_sel;
    logic [3:0]         slot_index;
    logic [ADDR_W-1:0]  address;
    logic [2:0]         match_len;
    logic [COUNT_W-1:0] path_count;
    logic [COUNT_W-1:0] first_unused;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [SLOT_W-1:0]  out_slot;
    logic [ADDR_W-1:0]  out_address;
    logic [COUNT_W-1:0] out_count;
    logic               last;
  } res_t;

  // Verdict of the address match unit for one table entry
  typedef struct packed {
    logic              present;
    logic              hit;
    logic              hop_ok;
    logic [ADDR_W-1:0] new_addr;
  } match_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PATH_RD,
    S_PATH_LD,
    S_SCAN,
    S_EMIT_RD,
    S_EMIT_LD,
    S_NONE
  } state_t;

endpackage

>>> sv/dpr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module dpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/dpr_match.sv
// ----------------------------------------------------------------------------
// Address match unit
// Compares the working path address against one table entry and works out
// the rewritten address, including the hop count step of an alias.
// ----------------------------------------------------------------------------
module dpr_match (
  input  logic [dpr_pkg::ADDR_W-1:0] cur,
  input  logic [dpr_pkg::TAB_W-1:0]  entry,
  input  logic [1:0]                 lst,
  input  logic [3:0]                 limit,
  output dpr_pkg::match_t            m
);
  import dpr_pkg::*;

  logic       plain_hit;
  logic       lead_hit;
  logic [2:0] n;
  logic [3:0] hops;
  logic [3:0] lim;
  logic [3:0] h;
  logic [7:0] ssid;

  always_comb begin
    plain_hit = (cur[ADDR_W-1:8] == entry[ADDR_W-1:8]) &&
                (((cur[7:0] ^ entry[7:0]) & SSID_HOPS) == 8'h00);

    // Leading bytes compared, byte 0 in the top bits; zero bytes match all.
    n        = entry[TAB_W-1:ADDR_W];
    lead_hit = 1'b1;
    for (int b = 0; b < 7; b++) begin
      if ((3'(b) < n) && (cur[ADDR_W-1-8*b -: 8] != entry[ADDR_W-1-8*b -: 8])) begin
        lead_hit = 1'b0;
      end
    end

    hops = cur[4:1];
    lim  = (hops > limit) ? limit : hops;
    h    = lim - 4'd1;
    ssid = {3'b000, h, 1'b0} | ((h == 4'd0) ? SSID_DONE : SSID_FIXED);

    m.present  = (entry[ADDR_W-1:ADDR_W-8] != 8'h00);
    m.hit      = (lst == LIST_PLAIN) ? plain_hit : lead_hit;
    m.hop_ok   = (lim != 4'd0);
    m.new_addr = (lst == LIST_PLAIN) ? (cur | {48'h0, USED_BIT})
                                     : {cur[ADDR_W-1:8], ssid};
  end

endmodule

>>> sv/digipeater_path_rewrite.sv
// ----------------------------------------------------------------------------
// Digipeater path rewrite
// Loads alias tables and a digipeater path, then rewrites the path for a
// relay decision and streams the rewritten slots out one word at a time.
// ----------------------------------------------------------------------------
// Timing: a load word completes in its accept cycle. A process word reads
//   the first unused slot, scans the table entries one at a time, then sends
//   its result words; a bad geometry goes straight to an action-none word.
// Throughput: one word at a time; the table scan through the single table
//   RAM read port bounds it, with output stalls added on top.
// Reset: synchronous; clears the state machine, the output valid and the table
//   entry valid bits, and sets the own call to zero and both hop limits to 2.
// ----------------------------------------------------------------------------
module digipeater_path_rewrite (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dpr_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [dpr_pkg::ADDR_W-1:0]    cfg_data,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  dpr_pkg::cmd_t                 cmd,
  output logic                          res_valid,
  input  logic                          res_ready,
  output dpr_pkg::res_t                 res
);
  import dpr_pkg::*;

  // Configuration registers.
  logic [ADDR_W-1:0] own_call;
  logic [3:0]        max_trace;
  logic [3:0]        max_flood;

  // Sequencer state and working registers of one process word.
  state_t             state;
  state_t             state_next;
  logic [COUNT_W-1:0] cnt;
  logic [SLOT_W-1:0]  f;
  logic [1:0]         ptr_lst;
  logic [1:0]         ptr_lst_next;
  logic [TIDX_W-1:0]  ptr_idx;
  logic [TIDX_W-1:0]  ptr_idx_next;
  logic [ADDR_W-1:0]  cur;
  logic [1:0]         act;
  logic               ins;
  logic [COUNT_W-1:0] cnt_out;
  logic [SLOT_W-1:0]  slot;

  // Table entry valid bits: an entry never written reads as zero, which
  // ends its table at that point just as after reset.
  logic [2:0][TIDX_N-1:0] vld;

  logic              cmd_acc;
  logic              out_free;
  logic              geo_bad;
  logic [TIDX_W+3:0] idx_ext;
  logic              tab_we;
  logic              path_we;
  logic [TAB_AW-1:0] tab_waddr;
  logic [TAB_AW-1:0] tab_raddr;
  logic [TAB_W-1:0]  tab_rdata;
  logic [TAB_W-1:0]  entry;
  logic [SLOT_W-1:0] path_raddr;
  logic [ADDR_W-1:0] path_rdata;
  logic [3:0]        limit;
  match_t            m;

  logic              list_end;
  logic              scan_take;
  logic              scan_none;

  logic              is_f;
  logic              is_f1;
  logic              shift_src;
  logic              slot_last;
  logic [ADDR_W-1:0] word_addr;

  // --------------------------------------------------------------------------
  // Input side decode. Loads complete in the accept cycle; table and path
  // writes go straight to the RAMs.
  // --------------------------------------------------------------------------
  assign cmd_ready = (state == S_IDLE);
  assign cmd_acc   = cmd_valid && cmd_ready;
  assign out_free  = !res_valid || res_ready;

  assign idx_ext   = {{TIDX_W{1'b0}}, cmd.slot_index};
  assign tab_waddr = {cmd.list_sel, idx_ext[TIDX_W-1:0]};
  assign tab_we    = cmd_acc && (cmd.func == FUNC_LOAD_TABLE) &&
                     (cmd.list_sel != LIST_UNUSED) &&
                     (idx_ext < (TIDX_W + 4)'(TABLE_DEPTH));
  assign path_we   = cmd_acc && (cmd.func == FUNC_LOAD_PATH) &&
                     (cmd.slot_index < COUNT_W'(MAX_PATH));

  // A path geometry that makes no sense gives action none at once.
  assign geo_bad = (cmd.path_count == '0) || (cmd.path_count > COUNT_W'(MAX_PATH)) ||
                   (cmd.first_unused == '0) || (cmd.first_unused > cmd.path_count);

  // All three tables share one RAM, addressed by table select and index.
  dpr_ram #(
    .WIDTH (TAB_W),
    .DEPTH (TAB_DEPTH)
  ) u_tab_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata ({cmd.match_len, cmd.address}),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  dpr_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (MAX_PATH)
  ) u_path_ram (
    .clk   (clk),
    .we    (path_we),
    .waddr (cmd.slot_index[SLOT_W-1:0]),
    .wdata (cmd.address),
    .raddr (path_raddr),
    .rdata (path_rdata)
  );

  // --------------------------------------------------------------------------
  // Table scan. The table RAM is addressed with the next scan pointer, so
  // the entry at the current pointer is on the read data in every scan
  // cycle and one entry is checked per cycle by the shared match unit.
  // --------------------------------------------------------------------------
  assign entry = vld[ptr_lst][ptr_idx] ? tab_rdata : '0;
  assign limit = (ptr_lst == LIST_TRACE) ? max_trace : max_flood;

  dpr_match u_match (
    .cur   (cur),
    .entry (entry),
    .lst   (ptr_lst),
    .limit (limit),
    .m     (m)
  );

  always_comb begin
    // A table ends at an empty entry or after its last entry.
    list_end  = !m.present || (!m.hit && (ptr_idx == IDX_LAST));
    // The first matching entry decides; an alias whose clamped hop count is
    // zero decides too, for no relay.
    scan_take = m.present && m.hit && ((ptr_lst == LIST_PLAIN) || m.hop_ok);
    scan_none = (m.present && m.hit && (ptr_lst != LIST_PLAIN) && !m.hop_ok) ||
                (list_end && (ptr_lst == LIST_FLOOD));
  end

  // --------------------------------------------------------------------------
  // Emission. With a trace relay into a path that has room, the own call
  // goes into the first unused slot and the rewritten alias and all later
  // slots move up by one; with a full path the own call replaces the alias.
  // --------------------------------------------------------------------------
  always_comb begin
    is_f      = (slot == f);
    is_f1     = ins && ({1'b0, slot} == ({1'b0, f} + 4'd1));
    shift_src = ins && ({1'b0, slot} > ({1'b0, f} + 4'd1));
    slot_last = (({1'b0, slot} + 4'd1) == cnt_out);

    if ((act == ACT_TRACE) && is_f) begin
      word_addr = own_call | {48'h0, USED_BIT};
    end else if ((act == ACT_TRACE) ? is_f1 : is_f) begin
      word_addr = cur;
    end else begin
      word_addr = path_rdata;
    end
    // End-of-address bit on the final slot.
    if (slot_last) begin
      word_addr[0] = 1'b1;
    end
  end

  // Before the decision the path RAM reads the first unused slot; while
  // emitting it reads the source slot of the word being built.
  always_comb begin
    if ((state == S_EMIT_RD) || (state == S_EMIT_LD)) begin
      path_raddr = shift_src ? (slot - 3'd1) : slot;
    end else begin
      path_raddr = f;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state.
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_acc && (cmd.func == FUNC_PROCESS)) begin
          state_next = geo_bad ? S_NONE : S_PATH_RD;
        end
      end
      S_PATH_RD: begin
        state_next = S_PATH_LD;
      end
      S_PATH_LD: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (scan_none) begin
          state_next = S_NONE;
        end else if (scan_take) begin
          state_next = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (out_free) begin
          state_next = slot_last ? S_IDLE : S_EMIT_RD;
        end
      end
      S_NONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: scan pointer and table read address.
  // --------------------------------------------------------------------------
  always_comb begin
    ptr_lst_next = ptr_lst;
    ptr_idx_next = ptr_idx;
    case (state)
      S_PATH_LD: begin
        ptr_lst_next = LIST_PLAIN;
        ptr_idx_next = '0;
      end
      S_SCAN: begin
        if (!scan_take && !scan_none) begin
          if (list_end) begin
            ptr_lst_next = ptr_lst + 2'd1;
            ptr_idx_next = '0;
          end else begin
            ptr_idx_next = ptr_idx + TIDX_W'(1);
          end
        end
      end
      default: begin
        ptr_lst_next = ptr_lst;
        ptr_idx_next = ptr_idx;
      end
    endcase
    tab_raddr = {ptr_lst_next, ptr_idx_next};
  end

  // --------------------------------------------------------------------------
  // Registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      vld       <= '0;
      own_call  <= '0;
      max_trace <= 4'd2;
      max_flood <= 4'd2;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          REG_OWN_CALL:  own_call  <= cfg_data;
          REG_MAX_TRACE: max_trace <= cfg_data[3:0];
          REG_MAX_FLOOD: max_flood <= cfg_data[3:0];
          default: ;
        endcase
      end

      if (tab_we) begin
        vld[cmd.list_sel][idx_ext[TIDX_W-1:0]] <= 1'b1;
      end

      if (((state == S_EMIT_LD) || (state == S_NONE)) && out_free) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload and working registers need no reset.
  always_ff @(posedge clk) begin
    ptr_lst <= ptr_lst_next;
    ptr_idx <= ptr_idx_next;

    if (cmd_acc && (cmd.func == FUNC_PROCESS)) begin
      cnt <= cmd.path_count;
      f   <= SLOT_W'(cmd.first_unused - 4'd1);
    end

    if (state == S_PATH_LD) begin
      cur <= path_rdata;
    end

    if ((state == S_SCAN) && scan_take) begin
      cur  <= m.new_addr;
      slot <= '0;
      case (ptr_lst)
        LIST_PLAIN: act <= ACT_PLAIN;
        LIST_TRACE: act <= ACT_TRACE;
        default:    act <= ACT_FLOOD;
      endcase
      if ((ptr_lst == LIST_TRACE) && (cnt < COUNT_W'(MAX_PATH))) begin
        ins     <= 1'b1;
        cnt_out <= cnt + 4'd1;
      end else begin
        ins     <= 1'b0;
        cnt_out <= cnt;
      end
    end

    if ((state == S_EMIT_LD) && out_free) begin
      res.action      <= act;
      res.out_slot    <= slot;
      res.out_address <= word_addr;
      res.out_count   <= cnt_out;
      res.last        <= slot_last;
      slot            <= slot + 3'd1;
    end

    if ((state == S_NONE) && out_free) begin
      res.action      <= ACT_NONE;
      res.out_slot    <= '0;
      res.out_address <= '0;
      res.out_count   <= '0;
      res.last        <= 1'b1;
    end
  end

endmodule

>>> sv/dpr_checker.sv
// ----------------------------------------------------------------------------
// Digipeater path rewrite checker
// Port-level properties of the path rewrite block, bound to its top level.
// ----------------------------------------------------------------------------
module dpr_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_ready,
  input dpr_pkg::cmd_t cmd,
  input logic          res_valid,
  input logic          res_ready,
  input dpr_pkg::res_t res
);
  import dpr_pkg::*;

  // No result word is left pending after reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A stalled result word holds.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("result word changed while stalled");

  // A process word keeps the block busy for at least the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && (cmd.func == FUNC_PROCESS)) |=> !cmd_ready)
    else $error("ready right after a process word");

  // A no-relay result is a single final word with a zero count.
  a_none_form: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.action == ACT_NONE)) |->
    (res.last && (res.out_count == '0) && (res.out_address == '0)))
    else $error("malformed action none word");

  // The final word of a relay carries the last slot and the end bit.
  a_last_slot: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.last && (res.action != ACT_NONE)) |->
    ((({1'b0, res.out_slot} + 4'd1) == res.out_count) && res.out_address[0]))
    else $error("final word slot or end bit wrong");

endmodule

bind digipeater_path_rewrite dpr_checker u_dpr_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .cmd       (cmd),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

>>> bench/tb_digipeater_path_rewrite.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Digipeater path rewrite testbench
// Loads alias tables and path slots, sends process words, and checks every
// emitted slot word against a predictor of the rewrite.
// ----------------------------------------------------------------------------
module tb_digipeater_path_rewrite;
  import dpr_pkg::*;

  // Nothing accepted on either channel for this many cycles ends the run.
  // The slowest legal gap is a long send gap, a full scan of three tables,
  // and eight slot words each behind a long output stall.
  localparam int QUIET_LIMIT   = 4000;
  // A load word still in flight when the last slot word arrives completes in
  // its accept cycle; this margin covers it before any register write.
  localparam int SETTLE_CYCLES = 16;
  // A process word reads its first unused slot, scans the table entries and
  // emits its slot words.
  localparam int DRAIN_CYCLES  = 80;
  localparam int PHASES        = 5;
  localparam int PHASE_WORDS   = 44;

  // The package names no code for the fourth func value; the block ignores it.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // A few AX.25 calls, each byte shifted left by one as on the air.
  localparam logic [47:0] CALL_HOME  = 48'h9C_6E_98_8A_9A_40;
  localparam logic [47:0] CALL_WIDE2 = 48'hAE_92_88_8A_64_40;
  localparam logic [47:0] CALL_NC2   = 48'h9C_86_64_40_40_40;
  localparam logic [47:0] CALL_OWN   = 48'h96_6E_82_84_86_40;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the alias tables, the path and the
  // registers, predicts the slot words of each process word, and checks the
  // slot words that come out in order.
  // --------------------------------------------------------------------------
  class rewrite_scoreboard;
    logic [ADDR_W-1:0] plain_calls   [TABLE_DEPTH];
    logic [TAB_W-1:0]  trace_aliases [TABLE_DEPTH];
    logic [TAB_W-1:0]  flood_aliases [TABLE_DEPTH];
    logic [ADDR_W-1:0] path_slots    [MAX_PATH];
    logic [ADDR_W-1:0] own_call;
    logic [3:0]        trace_limit;
    logic [3:0]        flood_limit;
    res_t              expected_slots [$];
    int                errors;

    function new();
      foreach (plain_calls[i]) begin
        plain_calls[i]   = '0;
        trace_aliases[i] = '0;
        flood_aliases[i] = '0;
      end
      foreach (path_slots[i]) path_slots[i] = '0;
      own_call    = '0;
      trace_limit = 4'd2;
      flood_limit = 4'd2;
      errors      = 0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
      case (idx)
        REG_OWN_CALL:  own_call    = data;
        REG_MAX_TRACE: trace_limit = data[3:0];
        REG_MAX_FLOOD: flood_limit = data[3:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_slots.size();
    endfunction

    // Trace and flood entries compare only their first match_len bytes.
    function bit lead_hit(logic [ADDR_W-1:0] a, logic [TAB_W-1:0] e);
      int n;
      n = e[TAB_W-1 -: 3];
      if (n == 0) return 1'b1;
      return ((a ^ e[ADDR_W-1:0]) >> (8 * (7 - n))) == '0;
    endfunction

    // Clamp and decrement the SSID hop count; the top bit says it was done.
    function logic [ADDR_W:0] hop_step(logic [ADDR_W-1:0] a, logic [3:0] limit);
      logic [3:0] hops;
      hops = a[4:1];
      if (hops > limit) hops = limit;
      if (hops == 4'd0) return {1'b0, a};
      hops = hops - 4'd1;
      a[7:0] = (hops == 4'd0) ? SSID_DONE : ({3'b000, hops, 1'b0} | SSID_FIXED);
      return {1'b1, a};
    endfunction

    function void rewrite_path(logic [3:0] count_in, logic [3:0] first_in);
      logic [ADDR_W-1:0] work [MAX_PATH+1];
      logic [ADDR_W:0]   step;
      logic [1:0]        act;
      res_t              r;
      int                cnt;
      int                f;
      bit                decided;
      act     = ACT_NONE;
      decided = 1'b0;
      cnt     = count_in;
      f       = int'(first_in) - 1;
      if (cnt >= 1 && cnt <= MAX_PATH && first_in >= 1 && first_in <= count_in) begin
        for (int i = 0; i < MAX_PATH; i++) work[i] = path_slots[i];
        work[MAX_PATH] = '0;
        for (int i = 0; i < TABLE_DEPTH && !decided; i++) begin
          if (plain_calls[i][ADDR_W-1 -: 8] == 8'h00) break;
          if (work[f][ADDR_W-1:8] == plain_calls[i][ADDR_W-1:8] &&
              work[f][4:1] == plain_calls[i][4:1]) begin
            work[f] = work[f] | ADDR_W'(USED_BIT);
            act     = ACT_PLAIN;
            decided = 1'b1;
          end
        end
        for (int i = 0; i < TABLE_DEPTH && !decided; i++) begin
          if (trace_aliases[i][ADDR_W-1 -: 8] == 8'h00) break;
          if (lead_hit(work[f], trace_aliases[i])) begin
            decided = 1'b1;
            step    = hop_step(work[f], trace_limit);
            if (step[ADDR_W]) begin
              work[f] = step[ADDR_W-1:0];
              // Room left: the alias moves up one slot behind our call.
              if (cnt < MAX_PATH) begin
                for (int j = cnt; j > f; j--) work[j] = work[j-1];
                cnt++;
              end
              work[f] = own_call | ADDR_W'(USED_BIT);
              act     = ACT_TRACE;
            end
          end
        end
        for (int i = 0; i < TABLE_DEPTH && !decided; i++) begin
          if (flood_aliases[i][ADDR_W-1 -: 8] == 8'h00) break;
          if (lead_hit(work[f], flood_aliases[i])) begin
            decided = 1'b1;
            step    = hop_step(work[f], flood_limit);
            if (step[ADDR_W]) begin
              work[f] = step[ADDR_W-1:0];
              act     = ACT_FLOOD;
            end
          end
        end
      end
      if (act == ACT_NONE) begin
        r      = '0;
        r.last = 1'b1;
        expected_slots.push_back(r);
      end else begin
        for (int i = 0; i < cnt; i++) begin
          r.action      = act;
          r.out_slot    = SLOT_W'(i);
          r.out_address = work[i];
          r.out_count   = COUNT_W'(cnt);
          r.last        = (i == cnt - 1);
          if (r.last) r.out_address[0] = 1'b1;
          expected_slots.push_back(r);
        end
      end
    endfunction

    function void note_word(cmd_t c);
      case (c.func)
        FUNC_LOAD_TABLE: begin
          if (c.slot_index < TABLE_DEPTH) begin
            case (c.list_sel)
              LIST_PLAIN: plain_calls[c.slot_index]   = c.address;
              LIST_TRACE: trace_aliases[c.slot_index] = {c.match_len, c.address};
              LIST_FLOOD: flood_aliases[c.slot_index] = {c.match_len, c.address};
              default: ;
            endcase
          end
        end
        FUNC_LOAD_PATH: begin
          if (c.slot_index < MAX_PATH) path_slots[c.slot_index[SLOT_W-1:0]] = c.address;
        end
        FUNC_PROCESS: rewrite_path(c.path_count, c.first_unused);
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_word(res_t got);
      res_t want;
      if (expected_slots.size() == 0) begin
        $error("slot word with nothing expected: 0x%0h", got);
        errors++;
        return;
      end
      want = expected_slots.pop_front();
      compare_field("action", want.action, got.action);
      compare_field("out_slot", want.out_slot, got.out_slot);
      compare_field("out_address", want.out_address, got.out_address);
      compare_field("out_count", want.out_count, got.out_count);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block
  // --------------------------------------------------------------------------
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_data  = '0;
  logic                 cmd_valid = 1'b0;
  logic                 cmd_ready;
  cmd_t                 cmd       = '0;
  logic                 res_valid;
  logic                 res_ready = 1'b0;
  res_t                 res;

  rewrite_scoreboard sb;
  logic [47:0]       call_pool [8];
  int                words_sent   = 0;
  int                quiet_cycles = 0;
  int                ready_hold   = 0;
  bit                no_idle      = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  digipeater_path_rewrite u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Most gaps are zero or short; now and then a long one. In a phase
  // without idling both sides run flat out.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // The output side picks at random between ready stretches and stalls of the
  // same length mix as the input gaps, so stalls can land on any slot word.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (no_idle) begin
      res_ready <= 1'b1;
    end else if ($urandom_range(0, 1) == 1) begin
      res_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 15);
    end else begin
      res_ready  <= 1'b0;
      ready_hold <= pick_gap();
    end
  end

  // Every accepted slot word is checked at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) sb.check_word(res);
  end

  // The watchdog counts cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("digipeater_path_rewrite: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers. Every task starts and ends on a rising edge. After a word is
  // accepted, valid stays high only if the next word follows at once, so it
  // is never lowered and raised in the same step.
  // --------------------------------------------------------------------------
  task automatic send_word(input cmd_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (!cmd_ready);
    sb.note_word(c);
    if (c.func != FUNC_UNUSED && !(c.func == FUNC_LOAD_TABLE && c.list_sel == LIST_UNUSED))
      words_sent++;
  endtask

  task automatic load_entry(input logic [1:0] sel, input logic [3:0] idx,
                            input logic [2:0] mlen, input logic [ADDR_W-1:0] a);
    cmd_t c;
    c            = '0;
    c.func       = FUNC_LOAD_TABLE;
    c.list_sel   = sel;
    c.slot_index = idx;
    c.match_len  = mlen;
    c.address    = a;
    send_word(c);
  endtask

  task automatic load_slot(input int idx, input logic [ADDR_W-1:0] a);
    cmd_t c;
    c            = '0;
    c.func       = FUNC_LOAD_PATH;
    c.slot_index = 4'(idx);
    c.address    = a;
    send_word(c);
  endtask

  task automatic process_path(input int count, input int first);
    cmd_t c;
    c              = '0;
    c.func         = FUNC_PROCESS;
    c.path_count   = 4'(count);
    c.first_unused = 4'(first);
    send_word(c);
  endtask

  // Registers change only with the block idle: every slot word in, and any
  // trailing load word given time to land.
  task automatic set_registers(input logic [ADDR_W-1:0] own, input logic [3:0] tr,
                               input logic [3:0] fl);
    cmd_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_OWN_CALL;
    cfg_data  <= own;
    sb.set_reg(REG_OWN_CALL, own);
    @(posedge clk);
    cfg_index <= REG_MAX_TRACE;
    cfg_data  <= ADDR_W'(tr);
    sb.set_reg(REG_MAX_TRACE, ADDR_W'(tr));
    @(posedge clk);
    cfg_index <= REG_MAX_FLOOD;
    cfg_data  <= ADDR_W'(fl);
    sb.set_reg(REG_MAX_FLOOD, ADDR_W'(fl));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [ADDR_W-1:0] pool_call();
    logic [7:0] ssid;
    ssid = 8'($urandom_range(0, 255));
    return {call_pool[$urandom_range(0, 7)], ssid};
  endfunction

  // One random step. Most steps are frames: a few path slots loaded, the
  // first unused one usually copied from a table entry so that it hits,
  // then a process word. Table reloads keep the tables moving, and a small
  // share of fully random words covers every field bit and the odd codes.
  task automatic random_step();
    cmd_t              c;
    logic [95:0]       raw;
    logic [ADDR_W-1:0] a;
    logic [2:0]        mlen;
    int                r;
    int                cnt;
    int                first;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      a    = ($urandom_range(0, 99) < 6) ? {8'h00, 48'($urandom_range(0, 255))}
                                         : pool_call();
      mlen = ($urandom_range(0, 9) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
      load_entry(2'($urandom_range(0, 2)),
                 ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 4))
                                              : 4'($urandom_range(0, 15)),
                 mlen, a);
    end else if (r < 88) begin
      cnt   = ($urandom_range(0, 3) == 0) ? MAX_PATH : $urandom_range(1, MAX_PATH);
      first = $urandom_range(1, cnt);
      repeat ($urandom_range(0, 2)) load_slot($urandom_range(0, MAX_PATH - 1), pool_call());
      if ($urandom_range(0, 99) < 75) begin
        case ($urandom_range(0, 2))
          0:       a = sb.plain_calls[$urandom_range(0, 3)];
          1:       a = sb.trace_aliases[$urandom_range(0, 3)][ADDR_W-1:0];
          default: a = sb.flood_aliases[$urandom_range(0, 3)][ADDR_W-1:0];
        endcase
        if (a[ADDR_W-1 -: 8] == 8'h00) a = pool_call();
        if ($urandom_range(0, 1) == 1) a[7:0] = 8'($urandom_range(0, 255));
      end else begin
        a = pool_call();
      end
      load_slot(first - 1, a);
      process_path(cnt, first);
    end else begin
      raw = {$urandom(), $urandom(), $urandom()};
      c   = cmd_t'(raw[$bits(cmd_t)-1:0]);
      send_word(c);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    cmd_t c;
    logic [63:0] w;
    sb = new();
    call_pool[0] = CALL_HOME;
    call_pool[1] = CALL_WIDE2;
    call_pool[2] = CALL_NC2;
    call_pool[3] = CALL_OWN;
    for (int i = 4; i < 8; i++) begin
      w = {$urandom(), $urandom()};
      call_pool[i] = w[47:0];
      if (call_pool[i][47:40] == 8'h00) call_pool[i][47:40] = 8'h82;
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    set_registers({CALL_OWN, 8'h6A}, 4'd7, 4'd3);

    // Directed part. One entry per table, then every path slot loaded so
    // that no process word ever reads a slot that was never written.
    load_entry(LIST_PLAIN, 4'd0, 3'd0, {CALL_HOME, 8'h62});
    load_entry(LIST_TRACE, 4'd0, 3'd4, {CALL_WIDE2, 8'h64});
    load_entry(LIST_FLOOD, 4'd0, 3'd2, {CALL_NC2, 8'h64});
    for (int i = 0; i < MAX_PATH; i++) load_slot(i, pool_call());

    // Plain call match: only the used bit changes.
    load_slot(0, {CALL_HOME, 8'h62});
    process_path(3, 1);
    // Trace alias with room: our call goes in and the path grows.
    load_slot(1, {CALL_WIDE2, 8'h64});
    process_path(3, 2);
    // Trace alias with a full path: our call replaces the alias.
    process_path(MAX_PATH, 2);
    // Hop count above the limit is clamped before the decrement.
    load_slot(1, {CALL_WIDE2, 8'h7E});
    process_path(2, 2);
    // Hop count that reaches zero marks the alias used.
    load_slot(1, {CALL_WIDE2, 8'h62});
    process_path(4, 2);
    // Alias with no hops left gives no action.
    load_slot(1, {CALL_WIDE2, 8'h60});
    process_path(2, 2);
    // Flood alias only loses a hop.
    load_slot(2, {CALL_NC2, 8'h66});
    process_path(3, 3);
    // Nothing matches.
    load_slot(2, {8'h02, 40'h0, 8'h66});
    process_path(3, 3);
    // Bad path geometry: no slots, too many slots, first unused out of range.
    process_path(0, 1);
    process_path(15, 15);
    process_path(4, 5);
    process_path(4, 0);
    // Ignored words: unused table select and unused func code.
    load_entry(LIST_UNUSED, 4'd0, 3'd0, pool_call());
    c      = '0;
    c.func = FUNC_UNUSED;
    send_word(c);
    // A flood entry with no compared bytes catches anything, until an entry
    // with a zero first byte is written over it and ends the table there again.
    load_entry(LIST_FLOOD, 4'd1, 3'd0, {8'hFF, 48'h0});
    process_path(3, 3);
    load_entry(LIST_FLOOD, 4'd1, 3'd0, '0);
    process_path(3, 3);

    // Random phases, the register extremes first.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       set_registers('0, 4'd1, 4'd1);
        1:       set_registers('1, 4'd15, 4'd15);
        default: begin
          w = {$urandom(), $urandom()};
          set_registers(w[ADDR_W-1:0], 4'($urandom_range(1, 15)),
                        4'($urandom_range(1, 15)));
        end
      endcase
      no_idle <= (p == 2);
      words_sent = 0;
      while (words_sent < PHASE_WORDS) random_step();
    end

    cmd_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("digipeater_path_rewrite: match");
    end else begin
      $display("digipeater_path_rewrite: mismatch");
    end
    $finish;
  end

endmodule
